// ===== src/obe_pkg.sv =====
// Shared constants, types and helper functions for the ORAM bucket engine.
`default_nettype none

package obe_pkg;

    localparam int SLOTS        = 4;
    localparam int LEAF_BITS    = 16;
    localparam int ID_BITS      = 32;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH_W = $clog2(LEAF_BITS + 1);

    typedef enum logic [1:0] {
        FN_READ_RM = 2'd0,
        FN_ADD     = 2'd1,
        FN_POP     = 2'd2,
        FN_DEEPEST = 2'd3
    } func_t;

    // Operation record that walks the row of slot cells.
    typedef struct packed {
        logic                    valid;
        logic                    en;
        func_t                   func;
        logic [ID_BITS-1:0]      key;
        logic [LEAF_BITS-1:0]    leaf;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [LEAF_BITS-1:0]    path;
        logic                    hit;
        logic [ID_BITS-1:0]      rid;
        logic [LEAF_BITS-1:0]    rleaf;
        logic [PAYLOAD_BITS-1:0] rpay;
        logic [DEPTH_W-1:0]      rdepth;
        logic                    present;
        logic                    empty_found;
        logic [IDX_W-1:0]        empty_idx;
    } carry_t;

    // Leading zeros of x, LEAF_BITS when x is zero.
    function automatic logic [DEPTH_W-1:0] lead_zeros(input logic [LEAF_BITS-1:0] x);
        logic [DEPTH_W-1:0] n;
        n = DEPTH_W'(LEAF_BITS);
        for (int b = 0; b < LEAF_BITS; b++) begin
            if (x[b]) begin
                n = DEPTH_W'(LEAF_BITS - 1 - b);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/obe_cell.sv =====
// One bucket slot: holds a block and updates the passing operation record.
`default_nettype none

module obe_cell (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            adv,
    input  wire logic [obe_pkg::IDX_W-1:0]        cell_idx,
    input  wire obe_pkg::carry_t                 carry_in,
    input  wire logic                            wr_en,
    input  wire logic [obe_pkg::ID_BITS-1:0]      wr_id,
    input  wire logic [obe_pkg::LEAF_BITS-1:0]    wr_leaf,
    input  wire logic [obe_pkg::PAYLOAD_BITS-1:0] wr_payload,
    output obe_pkg::carry_t                      carry_out,
    output logic                                 slot_valid
);

    logic                            slot_valid_reg;
    logic [obe_pkg::ID_BITS-1:0]      slot_id_reg;
    logic [obe_pkg::LEAF_BITS-1:0]    slot_leaf_reg;
    logic [obe_pkg::PAYLOAD_BITS-1:0] slot_payload_reg;
    obe_pkg::carry_t                 carry_out_reg;
    obe_pkg::carry_t                 carry_next;
    logic                            kill;
    logic                            match;
    logic [obe_pkg::DEPTH_W-1:0]      depth;

    always_comb begin
        carry_next = carry_in;
        kill       = 1'b0;
        depth      = obe_pkg::lead_zeros(slot_leaf_reg ^ carry_in.path);
        match      = slot_valid_reg && (slot_id_reg == carry_in.key);
        if (carry_in.valid && carry_in.en) begin
            case (carry_in.func)
                obe_pkg::FN_READ_RM: begin
                    if (match) begin
                        carry_next.hit   = 1'b1;
                        carry_next.rid   = slot_id_reg;
                        carry_next.rleaf = slot_leaf_reg;
                        carry_next.rpay  = slot_payload_reg;
                        kill             = 1'b1;
                    end
                end
                obe_pkg::FN_ADD: begin
                    if (match) begin
                        carry_next.present = 1'b1;
                    end
                    if (!slot_valid_reg && !carry_in.empty_found) begin
                        carry_next.empty_found = 1'b1;
                        carry_next.empty_idx   = cell_idx;
                    end
                end
                obe_pkg::FN_POP: begin
                    if (slot_valid_reg && !carry_in.hit) begin
                        carry_next.hit   = 1'b1;
                        carry_next.rid   = slot_id_reg;
                        carry_next.rleaf = slot_leaf_reg;
                        carry_next.rpay  = slot_payload_reg;
                        kill             = 1'b1;
                    end
                end
                obe_pkg::FN_DEEPEST: begin
                    // ties go to the later slot
                    if (slot_valid_reg && (!carry_in.hit || depth >= carry_in.rdepth)) begin
                        carry_next.hit    = 1'b1;
                        carry_next.rdepth = depth;
                        carry_next.rid    = slot_id_reg;
                        carry_next.rleaf  = slot_leaf_reg;
                        carry_next.rpay   = slot_payload_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
        end else if (wr_en) begin
            slot_valid_reg <= 1'b1;
        end else if (adv && kill) begin
            slot_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_id_reg      <= wr_id;
            slot_leaf_reg    <= wr_leaf;
            slot_payload_reg <= wr_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_out_reg.valid <= 1'b0;
        end else if (adv) begin
            carry_out_reg <= carry_next;
        end
    end

    assign carry_out  = carry_out_reg;
    assign slot_valid = slot_valid_reg;

endmodule

`default_nettype wire

// ===== src/oram_bucket_engine.sv =====
// An accepted beat is registered at the head, then in each slot cell in turn; the result
// sits in an output register; a new beat is taken only once the last has left the row.
// The record walks the row one slot per cycle unless stalled, and an add commits
// its write as the record leaves; the row stalls only while the result is still held.
// Reset (aresetn low, synchronous) empties the bucket and drops any beat in flight.
`default_nettype none

module oram_bucket_engine (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_func,
    input  wire logic                            s_enable,
    input  wire logic [obe_pkg::ID_BITS-1:0]      s_key_id,
    input  wire logic [obe_pkg::LEAF_BITS-1:0]    s_new_leaf,
    input  wire logic [obe_pkg::PAYLOAD_BITS-1:0] s_new_payload,
    input  wire logic [obe_pkg::LEAF_BITS-1:0]    s_path_leaf,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic [obe_pkg::ID_BITS-1:0]           m_out_id,
    output logic [obe_pkg::LEAF_BITS-1:0]         m_out_leaf,
    output logic [obe_pkg::PAYLOAD_BITS-1:0]      m_out_payload,
    output logic [obe_pkg::DEPTH_W-1:0]           m_deepest_level,
    output logic                                 m_bucket_full,
    output logic                                 m_bucket_empty
);

    obe_pkg::carry_t                 head_reg;
    obe_pkg::carry_t                 head_next;
    obe_pkg::carry_t                 chain [obe_pkg::SLOTS+1];
    obe_pkg::carry_t                 tail;
    logic                            busy_reg;
    logic                            accept;
    logic                            adv;
    logic                            finish;
    logic                            commit;
    logic [obe_pkg::SLOTS-1:0]        valid_vec;
    logic [obe_pkg::SLOTS-1:0]        wr_vec;
    logic [obe_pkg::SLOTS-1:0]        after_vec;

    logic                            m_valid_reg;
    logic                            m_hit_reg;
    logic [obe_pkg::ID_BITS-1:0]      m_out_id_reg;
    logic [obe_pkg::LEAF_BITS-1:0]    m_out_leaf_reg;
    logic [obe_pkg::PAYLOAD_BITS-1:0] m_out_payload_reg;
    logic [obe_pkg::DEPTH_W-1:0]      m_deepest_level_reg;
    logic                            m_bucket_full_reg;
    logic                            m_bucket_empty_reg;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    assign tail   = chain[obe_pkg::SLOTS];
    // hold the row while the finished record cannot leave
    assign adv    = !(tail.valid && m_valid_reg && !m_ready);
    assign finish = tail.valid && adv;
    assign commit = finish && tail.en && (tail.func == obe_pkg::FN_ADD) &&
                    !tail.present && tail.empty_found;

    always_comb begin
        head_next             = '0;
        head_next.valid       = 1'b1;
        head_next.en          = s_enable;
        head_next.func        = obe_pkg::func_t'(s_func);
        head_next.key         = s_key_id;
        head_next.leaf        = s_new_leaf;
        head_next.payload     = s_new_payload;
        head_next.path        = s_path_leaf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else if (accept) begin
            head_reg <= head_next;
        end else begin
            head_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (finish) begin
            busy_reg <= 1'b0;
        end
    end

    assign chain[0] = head_reg;

    for (genvar k = 0; k < obe_pkg::SLOTS; k++) begin : g_cell
        assign wr_vec[k] = commit && (tail.empty_idx == obe_pkg::IDX_W'(k));

        obe_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .cell_idx   (obe_pkg::IDX_W'(k)),
            .carry_in   (chain[k]),
            .wr_en      (wr_vec[k]),
            .wr_id      (tail.key),
            .wr_leaf    (tail.leaf),
            .wr_payload (tail.payload),
            .carry_out  (chain[k+1]),
            .slot_valid (valid_vec[k])
        );
    end

    assign after_vec = valid_vec | wr_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_hit_reg           <= tail.hit;
            m_out_id_reg        <= tail.rid;
            m_out_leaf_reg      <= tail.rleaf;
            m_out_payload_reg   <= tail.rpay;
            m_deepest_level_reg <= tail.rdepth;
            m_bucket_full_reg   <= &after_vec;
            m_bucket_empty_reg  <= ~|after_vec;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_out_id        = m_out_id_reg;
    assign m_out_leaf      = m_out_leaf_reg;
    assign m_out_payload   = m_out_payload_reg;
    assign m_deepest_level = m_deepest_level_reg;
    assign m_bucket_full   = m_bucket_full_reg;
    assign m_bucket_empty  = m_bucket_empty_reg;

endmodule

`default_nettype wire

// ===== src/obe_checker.sv =====
// Port-level checks for the ORAM bucket engine, bound to the top level.
`default_nettype none

module obe_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_hit,
    input wire logic [obe_pkg::ID_BITS-1:0]      m_out_id,
    input wire logic [obe_pkg::LEAF_BITS-1:0]    m_out_leaf,
    input wire logic [obe_pkg::PAYLOAD_BITS-1:0] m_out_payload,
    input wire logic [obe_pkg::DEPTH_W-1:0]      m_deepest_level,
    input wire logic                            m_bucket_full,
    input wire logic                            m_bucket_empty
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_out_id) &&
        $stable(m_out_payload) && $stable(m_bucket_full))
        else $error("result beat changed while stalled");

    // one operation in the slot row at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an operation is in flight");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_bucket_full && m_bucket_empty))
        else $error("bucket reported both full and empty");

    a_dummy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_out_id == '0 && m_out_leaf == '0 &&
        m_out_payload == '0 && m_deepest_level == '0)
        else $error("dummy result carries nonzero fields");

    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_deepest_level <= obe_pkg::DEPTH_W'(obe_pkg::LEAF_BITS))
        else $error("depth beyond leaf width");

endmodule

bind oram_bucket_engine obe_checker u_obe_checker (.*);

`default_nettype wire
